@@ rtl/sas_pkg.sv @@
`default_nettype none

package sas_pkg;

  // Fixed field widths
  localparam int DATA_W     = 32;
  localparam int DIM_W      = 10;
  localparam int FCOL_W     = 2;
  localparam int COEFF_FRAC = 24;

  // Configuration port: four 32-bit registers at 4*i
  localparam int CFG_AW = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_GRID_COLS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_COL  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEP_COEFF = 2'd3;

  localparam logic [DIM_W-1:0]  GRID_COLS_RST  = 10'd64;
  localparam logic [DIM_W-1:0]  GRID_ROWS_RST  = 10'd64;
  localparam logic [FCOL_W-1:0] FIRST_COL_RST  = 2'd1;
  localparam logic [DATA_W-1:0] STEP_COEFF_RST = 32'd16777216;

  // Default structural parameters
  localparam int LINE_DEPTH_DEF = 1024;
  localparam int ROW_LIMIT_DEF  = 1024;
  localparam int FRAC_BITS_DEF  = 16;

  // Scaled term clamps at 2^40
  localparam int CAP_W = 41;
  localparam logic [CAP_W-1:0] TERM_CAP = 41'h100_0000_0000;

  // Shared multiplier: 33 x 32 unsigned
  localparam int MUL_AW = 33;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  typedef struct packed {
    logic [DATA_W-1:0] ux_sample;
    logic [DATA_W-1:0] uy_sample;
    logic [DATA_W-1:0] dux_in;
    logic              frame_start;
  } sas_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] dux_out;
    logic [DIM_W-1:0]  out_row;
    logic [DIM_W-1:0]  out_col;
    logic              saturated;
    logic              frame_last;
  } sas_out_t;

  typedef struct packed {
    logic [DIM_W-1:0]  grid_cols;
    logic [DIM_W-1:0]  grid_rows;
    logic [FCOL_W-1:0] first_col;
    logic [DATA_W-1:0] step_coeff;
  } sas_cfg_t;

  typedef enum logic [1:0] {
    MUL_M  = 2'd0,
    MUL_P  = 2'd1,
    MUL_HI = 2'd2,
    MUL_LO = 2'd3
  } sas_mul_sel_t;

  typedef struct packed {
    logic         load;
    logic         rd_step;
    logic         mul_en;
    sas_mul_sel_t mul_sel;
    logic         s_first;
    logic         s_acc;
    logic         mag_en;
    logic         acc_en;
    logic         cap_en;
    logic         out_load;
  } sas_cmd_t;

  typedef struct packed {
    logic active;
    logic out_free;
  } sas_sts_t;

endpackage

`default_nettype wire

@@ rtl/sas_cfg.sv @@
`default_nettype none

module sas_cfg import sas_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic      [DATA_W-1:0] cfg_prdata,
  output logic                   cfg_pready,
  output sas_cfg_t               cfg
);

  logic [DIM_W-1:0]     grid_cols_r;
  logic [DIM_W-1:0]     grid_rows_r;
  logic [FCOL_W-1:0]    first_col_r;
  logic [DATA_W-1:0]    step_coeff_r;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[CFG_AW-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r  <= GRID_COLS_RST;
      grid_rows_r  <= GRID_ROWS_RST;
      first_col_r  <= FIRST_COL_RST;
      step_coeff_r <= STEP_COEFF_RST;
    end else if (wr_en) begin
      case (idx)
        REG_GRID_COLS:  grid_cols_r  <= cfg_pwdata[DIM_W-1:0];
        REG_GRID_ROWS:  grid_rows_r  <= cfg_pwdata[DIM_W-1:0];
        REG_FIRST_COL:  first_col_r  <= cfg_pwdata[FCOL_W-1:0];
        REG_STEP_COEFF: step_coeff_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GRID_COLS:  cfg_prdata = DATA_W'(grid_cols_r);
      REG_GRID_ROWS:  cfg_prdata = DATA_W'(grid_rows_r);
      REG_FIRST_COL:  cfg_prdata = DATA_W'(first_col_r);
      REG_STEP_COEFF: cfg_prdata = step_coeff_r;
      default:        cfg_prdata = '0;
    endcase
  end

  assign cfg.grid_cols  = grid_cols_r;
  assign cfg.grid_rows  = grid_rows_r;
  assign cfg.first_col  = first_col_r;
  assign cfg.step_coeff = step_coeff_r;

endmodule

`default_nettype wire

@@ rtl/sas_ctrl.sv @@
`default_nettype none

module sas_ctrl import sas_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  sas_sts_t      sts,
  output sas_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_M,
    ST_MUL_P,
    ST_SUM,
    ST_MAG,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_CAP,
    ST_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_M;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_step = 1'b1;
        state_nxt   = sts.active ? ST_MUL_M : ST_IDLE;
      end
      ST_MUL_M: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_M;
        state_nxt   = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P;
        cmd.s_first = 1'b1;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.s_acc = 1'b1;
        state_nxt = ST_MAG;
      end
      ST_MAG: begin
        cmd.mag_en = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HI;
        state_nxt   = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LO;
        cmd.acc_en  = 1'b1;
        state_nxt   = ST_CAP;
      end
      ST_CAP: begin
        cmd.cap_en = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register can take the beat
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sas_dp.sv @@
`default_nettype none

module sas_dp import sas_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF,
  parameter int ROW_LIMIT  = ROW_LIMIT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  sas_in_t   in_data,
  input  sas_cfg_t  cfg,
  input  sas_cmd_t  cmd,
  output sas_sts_t  sts,
  output logic      out_valid,
  input  wire logic out_stall,
  output sas_out_t  out_data
);

  localparam int COL_W = $clog2(LINE_DEPTH);
  localparam int ROW_W = $clog2(ROW_LIMIT);
  localparam int CCW   = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
  localparam int RCW   = ((ROW_W > DIM_W) ? ROW_W : DIM_W) + 1;
  // product term, its sum and the sum's magnitude
  localparam int TW    = 64 - FRAC_BITS;
  localparam int SW    = TW + 2;
  localparam int MW    = TW + 1;
  localparam int TMW   = MUL_PW + 1;
  localparam int TSW   = CAP_W + 1;
  localparam int RW    = TSW + 1;

  // line stores
  logic [DATA_W-1:0] older_mem [LINE_DEPTH];
  logic [DATA_W-1:0] prev_mem  [LINE_DEPTH];
  logic [DATA_W-1:0] uyp_mem   [LINE_DEPTH];
  logic [DATA_W-1:0] older_rd_r;
  logic [DATA_W-1:0] prev_rd_r;
  logic [DATA_W-1:0] uyp_rd_r;

  logic [COL_W-1:0]  col_cnt_r;
  logic [ROW_W-1:0]  row_cnt_r;
  logic [COL_W-1:0]  col_cnt_nxt;
  logic [ROW_W-1:0]  row_cnt_nxt;
  logic [DATA_W-1:0] uyl_cur_r;
  logic [DATA_W-1:0] uyl_prev_r;

  logic [DATA_W-1:0] ux_r;
  logic [DATA_W-1:0] uy_r;
  logic [DATA_W-1:0] dux_r;
  logic [COL_W-1:0]  pos_c_r;
  logic [ROW_W-1:0]  pos_r_r;
  logic              active_r;
  logic              last_r;

  logic [CCW-1:0]    cols_lim;
  logic [RCW-1:0]    rows_lim;
  logic [CCW-1:0]    fc;
  logic [COL_W-1:0]  pos_c;
  logic [ROW_W-1:0]  pos_r;
  logic [CCW-1:0]    pos_c_x;
  logic [RCW-1:0]    pos_rm1;
  logic [CCW-1:0]    c_inc;
  logic [RCW-1:0]    r_inc;

  logic [32:0]       sum_m, sum_p, adj_m, adj_p, half_m, half_p, dm, dp;
  logic [32:0]       neg_half_m, neg_half_p, neg_dm, neg_dp;
  logic [31:0]       am_mag_r, ap_mag_r;
  logic [32:0]       dm_mag_r, dp_mag_r;
  logic              am_neg_r, ap_neg_r, dm_neg_r, dp_neg_r;

  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic              mul_neg;
  logic [MUL_PW-1:0] prod_r;
  logic              prod_neg_r;
  logic [TW-1:0]     term_mag;
  logic [SW-1:0]     term_s;
  logic [SW-1:0]     s_r;
  logic [SW-1:0]     s_neg_val;
  logic [MW-1:0]     mag_r;
  logic              sneg_r;
  logic [MUL_PW-1:0] acc_r;
  logic [TMW-1:0]    tm;
  logic [CAP_W-1:0]  tcap_r;
  logic [TSW-1:0]    t_s;
  logic [RW-1:0]     res;
  logic              sat_hi, sat_lo;
  logic [DATA_W-1:0] res_sat;

  logic              out_valid_r;
  sas_out_t          out_data_r;

  // effective sizes
  assign cols_lim = (CCW'(cfg.grid_cols) > CCW'(LINE_DEPTH - 2)) ?
                    CCW'(LINE_DEPTH - 2) : CCW'(cfg.grid_cols);
  assign rows_lim = (RCW'(cfg.grid_rows) > RCW'(ROW_LIMIT - 2)) ?
                    RCW'(ROW_LIMIT - 2) : RCW'(cfg.grid_rows);
  assign fc       = (cfg.first_col == '0) ? CCW'(1) : CCW'(cfg.first_col);

  assign pos_c   = in_data.frame_start ? '0 : col_cnt_r;
  assign pos_r   = in_data.frame_start ? '0 : row_cnt_r;
  assign pos_c_x = CCW'(pos_c);
  assign pos_rm1 = RCW'(pos_r) - RCW'(1);

  // item capture and line store read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ux_r       <= in_data.ux_sample;
      uy_r       <= in_data.uy_sample;
      dux_r      <= in_data.dux_in;
      pos_c_r    <= pos_c;
      pos_r_r    <= pos_r;
      last_r     <= (pos_rm1 == rows_lim) && (pos_c_x == cols_lim);
      older_rd_r <= older_mem[pos_c];
      prev_rd_r  <= prev_mem[pos_c];
      uyp_rd_r   <= uyp_mem[pos_c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_step) begin
      older_mem[pos_c_r] <= prev_rd_r;
      prev_mem[pos_c_r]  <= ux_r;
      uyp_mem[pos_c_r]   <= uy_r;
    end
  end

  // raster advance
  assign c_inc = CCW'(pos_c_r) + CCW'(1);
  assign r_inc = RCW'(pos_r_r) + RCW'(1);

  always_comb begin
    if (c_inc >= cols_lim + CCW'(2)) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (r_inc >= rows_lim + RCW'(2)) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_cnt_nxt = c_inc[COL_W-1:0];
      row_cnt_nxt = pos_r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      uyl_cur_r  <= '0;
      uyl_prev_r <= '0;
      active_r   <= 1'b0;
    end else begin
      if (cmd.load) begin
        active_r <= (RCW'(pos_r) >= RCW'(2)) && (pos_rm1 <= rows_lim) &&
                    (pos_c_x >= fc) && (pos_c_x <= cols_lim);
      end
      if (cmd.rd_step) begin
        col_cnt_r  <= col_cnt_nxt;
        row_cnt_r  <= row_cnt_nxt;
        uyl_prev_r <= uyp_rd_r;
        uyl_cur_r  <= uy_r;
      end
    end
  end

  // face averages (halved toward zero) and one-sided differences
  assign sum_m  = {uyl_prev_r[31], uyl_prev_r} + {uyp_rd_r[31], uyp_rd_r};
  assign sum_p  = {uyl_cur_r[31], uyl_cur_r} + {uy_r[31], uy_r};
  assign adj_m  = sum_m + {32'b0, sum_m[32]};
  assign adj_p  = sum_p + {32'b0, sum_p[32]};
  assign half_m = {adj_m[32], adj_m[32:1]};
  assign half_p = {adj_p[32], adj_p[32:1]};
  assign dm     = {prev_rd_r[31], prev_rd_r} - {older_rd_r[31], older_rd_r};
  assign dp     = {ux_r[31], ux_r} - {prev_rd_r[31], prev_rd_r};

  assign neg_half_m = -half_m;
  assign neg_half_p = -half_p;
  assign neg_dm     = -dm;
  assign neg_dp     = -dp;

  always_ff @(posedge clk) begin
    if (cmd.rd_step) begin
      am_neg_r <= half_m[32];
      ap_neg_r <= half_p[32];
      dm_neg_r <= dm[32];
      dp_neg_r <= dp[32];
      am_mag_r <= half_m[32] ? neg_half_m[31:0] : half_m[31:0];
      ap_mag_r <= half_p[32] ? neg_half_p[31:0] : half_p[31:0];
      dm_mag_r <= dm[32] ? neg_dm : dm;
      dp_mag_r <= dp[32] ? neg_dp : dp;
    end
  end

  // shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      MUL_M: begin
        mul_a   = dm_mag_r;
        mul_b   = am_mag_r;
        mul_neg = am_neg_r ^ dm_neg_r;
      end
      MUL_P: begin
        mul_a   = dp_mag_r;
        mul_b   = ap_mag_r;
        mul_neg = ap_neg_r ^ dp_neg_r;
      end
      MUL_HI: begin
        mul_a   = MUL_AW'(mag_r[MW-1:COEFF_FRAC]);
        mul_b   = cfg.step_coeff;
        mul_neg = 1'b0;
      end
      MUL_LO: begin
        mul_a   = MUL_AW'(mag_r[COEFF_FRAC-1:0]);
        mul_b   = cfg.step_coeff;
        mul_neg = 1'b0;
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r     <= MUL_PW'(mul_a) * MUL_PW'(mul_b);
      prod_neg_r <= mul_neg;
    end
  end

  // truncate the magnitude, then restore the sign
  assign term_mag  = prod_r[FRAC_BITS+TW-1:FRAC_BITS];
  assign term_s    = prod_neg_r ? -SW'(term_mag) : SW'(term_mag);
  assign s_neg_val = -s_r;

  always_ff @(posedge clk) begin
    if (cmd.s_first) begin
      s_r <= term_s;
    end else if (cmd.s_acc) begin
      s_r <= s_r + term_s;
    end
    if (cmd.mag_en) begin
      sneg_r <= s_r[SW-1];
      mag_r  <= s_r[SW-1] ? s_neg_val[MW-1:0] : s_r[MW-1:0];
    end
    if (cmd.acc_en) begin
      acc_r <= prod_r;
    end
    if (cmd.cap_en) begin
      tcap_r <= (tm > TMW'(TERM_CAP)) ? TERM_CAP : tm[CAP_W-1:0];
    end
  end

  // coefficient scaling split at the Q8.24 point
  assign tm = TMW'(acc_r) + TMW'(prod_r[MUL_PW-1:COEFF_FRAC]);

  // subtract and clip
  assign t_s    = sneg_r ? -TSW'(tcap_r) : TSW'(tcap_r);
  assign res    = {{(RW - DATA_W){dux_r[DATA_W-1]}}, dux_r} - {t_s[TSW-1], t_s};
  assign sat_hi = !res[RW-1] && (res[RW-2:DATA_W-1] != '0);
  assign sat_lo = res[RW-1] && (res[RW-2:DATA_W-1] != '1);

  always_comb begin
    if (sat_hi) begin
      res_sat = {1'b0, {(DATA_W - 1){1'b1}}};
    end else if (sat_lo) begin
      res_sat = {1'b1, {(DATA_W - 1){1'b0}}};
    end else begin
      res_sat = res[DATA_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.dux_out    <= res_sat;
      out_data_r.out_row    <= DIM_W'(RCW'(pos_r_r) - RCW'(1));
      out_data_r.out_col    <= DIM_W'(CCW'(pos_c_r));
      out_data_r.saturated  <= sat_hi || sat_lo;
      out_data_r.frame_last <= last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign sts.active   = active_r;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

@@ rtl/staggered_advection_stencil_top.sv @@
// Channel  Direction  Handshake        Beat
// in_      input      valid / stall    sas_in_t: ux, uy, dux_in, frame_start
// out_     output     valid / stall    sas_out_t: dux_out, row, col, flags
// cfg_     input      APB, pready = 1  four 32-bit registers at 4*i
//
// An item that updates no point ends after the read state; one that updates a
// point runs on to the output state and waits there for the output register,
// using the one shared 33x32 multiplier four times per point in sequence.
// Synchronous active-low reset clears counters, left samples and control;
// line stores hold nothing until a frame has written them.
// Output register decouples the sides: a new item is taken while a beat waits.
`default_nettype none

module staggered_advection_stencil_top import sas_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF,
  parameter int ROW_LIMIT  = ROW_LIMIT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  sas_in_t                in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sas_out_t               out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic      [DATA_W-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  sas_cfg_t cfg;
  sas_cmd_t cmd;
  sas_sts_t sts;

  sas_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  sas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sas_dp #(
    .LINE_DEPTH (LINE_DEPTH),
    .ROW_LIMIT  (ROW_LIMIT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/sas_checker.sv @@
`default_nettype none

module sas_checker import sas_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input sas_in_t                in_data,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input sas_out_t               out_data,
  input wire logic              cfg_psel,
  input wire logic              cfg_penable,
  input wire logic              cfg_pwrite,
  input wire logic [CFG_AW-1:0] cfg_paddr,
  input wire logic [DATA_W-1:0] cfg_pwdata,
  input wire logic [DATA_W-1:0] cfg_prdata,
  input wire logic              cfg_pready
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // one item at a time: stall follows every accepted item
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // only interior points are reported
  a_out_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_row != '0) && (out_data.out_col != '0))
    else $error("result at a boundary position");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel |-> cfg_pready)
    else $error("configuration port not ready");

endmodule

bind staggered_advection_stencil_top sas_checker u_sas_checker (.*);

`default_nettype wire
